FILE: hw/rtl/hbrl_pkg.sv
// Shared types, widths and codes of the histogram bin range lookup.
package hbrl_pkg;

   // Table geometry and value widths
   localparam int MAX_BINS    = 256;
   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int INDEX_WIDTH = $clog2(MAX_BINS);
   localparam int CNT_WIDTH   = $clog2(MAX_BINS + 1);
   localparam int TOTAL_WIDTH = 40;

   // Port field widths
   localparam int OPCODE_WIDTH      = 2;
   localparam int STATUS_WIDTH      = 2;
   localparam int EDGE_FIELD_WIDTH  = 64;
   localparam int COUNT_FIELD_WIDTH = 32;
   localparam int INDEX_FIELD_WIDTH = 8;
   localparam int TOTAL_FIELD_WIDTH = 40;
   localparam int BINS_FIELD_WIDTH  = 9;

   typedef logic signed [VALUE_WIDTH-1:0] edge_type;
   typedef logic [COUNT_WIDTH-1:0]        count_type;
   typedef logic [INDEX_WIDTH-1:0]        index_type;
   typedef logic [CNT_WIDTH-1:0]          cnt_type;
   typedef logic [TOTAL_WIDTH-1:0]        total_type;

   typedef enum logic [OPCODE_WIDTH-1:0] {
      OP_LOAD            = 2'd0,
      OP_FIND_CONTAINING = 2'd1,
      OP_FIND_NEXT       = 2'd2,
      OP_CLEAR           = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // One stored bin
   typedef struct packed {
      edge_type  lower;
      edge_type  upper;
      count_type height;
      count_type distinct;
   } bin_entry_type;

   typedef struct packed {
      logic [OPCODE_WIDTH-1:0]             opcode;
      logic signed [EDGE_FIELD_WIDTH-1:0]  query_value;
      logic signed [EDGE_FIELD_WIDTH-1:0]  load_lower;
      logic signed [EDGE_FIELD_WIDTH-1:0]  load_upper;
      logic [COUNT_FIELD_WIDTH-1:0]        load_height;
      logic [COUNT_FIELD_WIDTH-1:0]        load_distinct;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0]             status;
      logic [INDEX_FIELD_WIDTH-1:0]        found_index;
      logic signed [EDGE_FIELD_WIDTH-1:0]  found_lower;
      logic signed [EDGE_FIELD_WIDTH-1:0]  found_upper;
      logic [COUNT_FIELD_WIDTH-1:0]        found_height;
      logic [COUNT_FIELD_WIDTH-1:0]        found_distinct;
      logic [TOTAL_FIELD_WIDTH-1:0]        sum_heights;
      logic [TOTAL_FIELD_WIDTH-1:0]        sum_distincts;
      logic [BINS_FIELD_WIDTH-1:0]         bins_loaded;
   } rsp_payload_type;

   // Microcode step addresses
   typedef enum logic [2:0] {
      UPC_IDLE  = 3'd0,
      UPC_LOAD  = 3'd1,
      UPC_CLEAR = 3'd2,
      UPC_STEP  = 3'd3,
      UPC_FETCH = 3'd4,
      UPC_CHECK = 3'd5
   } upc_type;

   // Jump conditions
   typedef enum logic [1:0] {
      COND_NEXT     = 2'd0,
      COND_DISPATCH = 2'd1,
      COND_SEARCH   = 2'd2
   } cond_type;

   // One control word
   typedef struct packed {
      logic     accept;
      logic     search_step;
      logic     fetch;
      logic     load;
      logic     clear;
      logic     check;
      logic     emit;
      cond_type cond;
      upc_type  next;
   } ucode_type;

   typedef struct packed {
      ucode_type word;
      logic      go;
   } seq_ctrl_type;

   typedef struct packed {
      logic search_more;
      logic rsp_busy;
   } dp_status_type;

endpackage

FILE: hw/rtl/hbrl_if.sv
// Request and response channel interfaces of the histogram bin range lookup.
interface hbrl_req_if
   import hbrl_pkg::*;
   ();
   logic                               valid;
   logic                               ready;
   logic [OPCODE_WIDTH-1:0]            opcode;
   logic signed [EDGE_FIELD_WIDTH-1:0] query_value;
   logic signed [EDGE_FIELD_WIDTH-1:0] load_lower;
   logic signed [EDGE_FIELD_WIDTH-1:0] load_upper;
   logic [COUNT_FIELD_WIDTH-1:0]       load_height;
   logic [COUNT_FIELD_WIDTH-1:0]       load_distinct;

   modport source (output valid, opcode, query_value, load_lower, load_upper,
                   load_height, load_distinct, input ready);
   modport sink (input valid, opcode, query_value, load_lower, load_upper,
                 load_height, load_distinct, output ready);
endinterface

interface hbrl_rsp_if
   import hbrl_pkg::*;
   ();
   logic                               valid;
   logic                               ready;
   logic [STATUS_WIDTH-1:0]            status;
   logic [INDEX_FIELD_WIDTH-1:0]       found_index;
   logic signed [EDGE_FIELD_WIDTH-1:0] found_lower;
   logic signed [EDGE_FIELD_WIDTH-1:0] found_upper;
   logic [COUNT_FIELD_WIDTH-1:0]       found_height;
   logic [COUNT_FIELD_WIDTH-1:0]       found_distinct;
   logic [TOTAL_FIELD_WIDTH-1:0]       sum_heights;
   logic [TOTAL_FIELD_WIDTH-1:0]       sum_distincts;
   logic [BINS_FIELD_WIDTH-1:0]        bins_loaded;

   modport source (output valid, status, found_index, found_lower, found_upper,
                   found_height, found_distinct, sum_heights, sum_distincts,
                   bins_loaded, input ready);
   modport sink (input valid, status, found_index, found_lower, found_upper,
                 found_height, found_distinct, sum_heights, sum_distincts,
                 bins_loaded, output ready);
endinterface

FILE: hw/rtl/hbrl_bin_store.sv
// Bin table memory: one write port, one registered read port.
module hbrl_bin_store
   import hbrl_pkg::*;
(
   input  logic          clock,
   input  logic          wr_en,
   input  index_type     wr_addr,
   input  bin_entry_type wr_data,
   input  logic          rd_en,
   input  index_type     rd_addr,
   output bin_entry_type rd_data
);

   bin_entry_type bin_mem_ff [MAX_BINS];
   bin_entry_type rd_data_ff;

   // Write a loaded bin
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bin_mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read one bin, hold the data otherwise
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= bin_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/hbrl_sequencer.sv
// Microcode sequencer: step register, control store and jump logic.
module hbrl_sequencer
   import hbrl_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  opcode_type    req_opcode,
   input  dp_status_type dp_status,
   output seq_ctrl_type  seq_ctrl
);

   upc_type   upc_ff;
   upc_type   upc_in;
   upc_type   target;
   ucode_type word;
   logic      go;

   // Control store: one word per step
   function automatic ucode_type ucode_rom(upc_type addr);
      ucode_type w;
      w = '{accept: 1'b0, search_step: 1'b0, fetch: 1'b0, load: 1'b0,
            clear: 1'b0, check: 1'b0, emit: 1'b0, cond: COND_NEXT, next: UPC_IDLE};
      case (addr)
         UPC_IDLE: begin
            w.accept = 1'b1;
            w.cond   = COND_DISPATCH;
         end
         UPC_LOAD: begin
            w.load = 1'b1;
            w.emit = 1'b1;
         end
         UPC_CLEAR: begin
            w.clear = 1'b1;
            w.emit  = 1'b1;
         end
         UPC_STEP: begin
            w.search_step = 1'b1;
            w.cond        = COND_SEARCH;
            w.next        = UPC_FETCH;
         end
         UPC_FETCH: begin
            w.fetch = 1'b1;
            w.next  = UPC_CHECK;
         end
         UPC_CHECK: begin
            w.check = 1'b1;
            w.emit  = 1'b1;
         end
         default: begin
            w.next = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

   // Branch on the opcode of the accepted request
   function automatic upc_type dispatch(opcode_type op, logic more);
      upc_type t;
      case (op)
         OP_LOAD:            t = UPC_LOAD;
         OP_FIND_CONTAINING: t = more ? UPC_STEP : UPC_FETCH;
         OP_FIND_NEXT:       t = more ? UPC_STEP : UPC_FETCH;
         OP_CLEAR:           t = UPC_CLEAR;
         default:            t = UPC_IDLE;
      endcase
      return t;
   endfunction

   assign word = ucode_rom(upc_ff);

   // Wait for a request in the accept step, hold an emit step while the result is blocked
   assign go = word.accept ? req_valid : !(word.emit && dp_status.rsp_busy);

   // Select the next step
   always_comb begin
      case (word.cond)
         COND_NEXT:     target = word.next;
         COND_DISPATCH: target = dispatch(req_opcode, dp_status.search_more);
         COND_SEARCH:   target = dp_status.search_more ? UPC_STEP : word.next;
         default:       target = word.next;
      endcase
      upc_in = go ? target : upc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign seq_ctrl = '{word: word, go: go};

endmodule

FILE: hw/rtl/hbrl_datapath.sv
// Datapath: request registers, search bounds, totals, bin table and result register.
module hbrl_datapath
   import hbrl_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  seq_ctrl_type    seq_ctrl,
   input  req_payload_type req_payload,
   input  logic            rsp_ready,
   output dp_status_type   dp_status,
   output logic            rsp_valid,
   output rsp_payload_type rsp_payload
);

   typedef logic [TOTAL_WIDTH:0] total_sum_type;

   localparam cnt_type CNT_ONE  = cnt_type'(1);
   localparam cnt_type CNT_FULL = cnt_type'(MAX_BINS);

   ucode_type       word;
   logic            go;

   opcode_type      opcode_ff;
   edge_type        value_ff;
   bin_entry_type   entry_ff;
   cnt_type         lo_ff, lo_in;
   cnt_type         hi_ff, hi_in;
   cnt_type         mid_ff, mid_in;
   logic [CNT_WIDTH:0] mid_sum;
   cnt_type         count_ff, count_in;
   total_type       height_total_ff, height_total_in;
   total_type       distinct_total_ff, distinct_total_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;

   bin_entry_type   rd_data;
   edge_type        rd_lower, rd_upper;
   logic            go_right;
   logic            table_full;
   logic            have_bin;
   logic            wr_en, rd_en;
   index_type       rd_addr;

   // Add a count to a total, saturating at the top of the total
   function automatic total_type sat_add(total_type total, count_type x);
      total_sum_type sum;
      sum = {1'b0, total} + total_sum_type'(x);
      return sum[TOTAL_WIDTH] ? '1 : sum[TOTAL_WIDTH-1:0];
   endfunction

   assign word = seq_ctrl.word;
   assign go   = seq_ctrl.go;

   assign rd_lower = rd_data.lower;
   assign rd_upper = rd_data.upper;

   // Steer the search bounds: reset on accept, halve on each compare
   always_comb begin
      go_right = (opcode_ff == OP_FIND_NEXT) ? !(value_ff < rd_upper)
                                             : (rd_upper < value_ff);
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (word.accept) begin
         lo_in = '0;
         hi_in = count_ff;
      end else if (word.search_step) begin
         if (go_right) begin
            lo_in = mid_ff + CNT_ONE;
         end else begin
            hi_in = mid_ff;
         end
      end
      mid_sum = {1'b0, lo_in} + {1'b0, hi_in};
      mid_in  = mid_sum[CNT_WIDTH:1];
   end

   assign dp_status.search_more = (lo_in < hi_in);
   assign dp_status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   // Table port control
   assign table_full = (count_ff >= CNT_FULL);
   assign wr_en      = go && word.load && !table_full;
   assign rd_en      = go && (word.accept || word.search_step || word.fetch);
   assign rd_addr    = word.fetch ? lo_ff[INDEX_WIDTH-1:0] : mid_in[INDEX_WIDTH-1:0];

   hbrl_bin_store u_bin_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[INDEX_WIDTH-1:0]),
      .wr_data (entry_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Update count and totals, build the result
   always_comb begin
      count_in          = count_ff;
      height_total_in   = height_total_ff;
      distinct_total_in = distinct_total_ff;
      if (word.load && !table_full) begin
         count_in          = count_ff + CNT_ONE;
         height_total_in   = sat_add(height_total_ff, entry_ff.height);
         distinct_total_in = sat_add(distinct_total_ff, entry_ff.distinct);
      end else if (word.clear) begin
         count_in          = '0;
         height_total_in   = '0;
         distinct_total_in = '0;
      end

      have_bin = (lo_ff < count_ff) &&
                 ((opcode_ff == OP_FIND_NEXT) ||
                  (!(value_ff < rd_lower) && !(rd_upper < value_ff)));

      rsp_in               = '0;
      rsp_in.status        = ST_OK;
      rsp_in.sum_heights   = TOTAL_FIELD_WIDTH'(height_total_in);
      rsp_in.sum_distincts = TOTAL_FIELD_WIDTH'(distinct_total_in);
      rsp_in.bins_loaded   = BINS_FIELD_WIDTH'(count_in);
      if (word.load) begin
         if (table_full) begin
            rsp_in.status = ST_FULL;
         end else begin
            rsp_in.found_index    = INDEX_FIELD_WIDTH'(count_ff);
            rsp_in.found_lower    = EDGE_FIELD_WIDTH'(entry_ff.lower);
            rsp_in.found_upper    = EDGE_FIELD_WIDTH'(entry_ff.upper);
            rsp_in.found_height   = COUNT_FIELD_WIDTH'(entry_ff.height);
            rsp_in.found_distinct = COUNT_FIELD_WIDTH'(entry_ff.distinct);
         end
      end else if (word.check) begin
         if (have_bin) begin
            rsp_in.found_index    = INDEX_FIELD_WIDTH'(lo_ff);
            rsp_in.found_lower    = EDGE_FIELD_WIDTH'(rd_lower);
            rsp_in.found_upper    = EDGE_FIELD_WIDTH'(rd_upper);
            rsp_in.found_height   = COUNT_FIELD_WIDTH'(rd_data.height);
            rsp_in.found_distinct = COUNT_FIELD_WIDTH'(rd_data.distinct);
         end else begin
            rsp_in.status = ST_NONE;
         end
      end

      // Hold the result until the transfer, then drop valid
      if (go && word.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff          <= '0;
         height_total_ff   <= '0;
         distinct_total_ff <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            count_ff          <= count_in;
            height_total_ff   <= height_total_in;
            distinct_total_ff <= distinct_total_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (go && word.accept) begin
         opcode_ff         <= opcode_type'(req_payload.opcode);
         value_ff          <= VALUE_WIDTH'(req_payload.query_value);
         entry_ff.lower    <= VALUE_WIDTH'(req_payload.load_lower);
         entry_ff.upper    <= VALUE_WIDTH'(req_payload.load_upper);
         entry_ff.height   <= COUNT_WIDTH'(req_payload.load_height);
         entry_ff.distinct <= COUNT_WIDTH'(req_payload.load_distinct);
      end
      if (go) begin
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         mid_ff <= mid_in;
      end
      if (go && word.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: hw/rtl/histogram_bin_range_lookup.sv
// Histogram bin range lookup: top level with request and response channels.
//
// Holds a table of up to MAX_BINS histogram bins, loaded in order after a
// clear, with running totals of heights and distinct counts. A load or a clear
// occupies the sequencer for the accept step and then the load or clear step,
// which registers its result. A query (find containing bin, find next bin)
// passes the accept step, the search steps, a fetch step and a check step: a
// microcoded sequencer walks a binary search for the first bin whose upper
// edge is not below (find containing) or above (find next) the query value,
// with one read of the bin table memory per step, then one more read of the
// candidate bin for the final check. The result sits in an output register;
// the next request is taken while it waits, and a new result is held back
// only until the previous one has transferred.
module histogram_bin_range_lookup
   import hbrl_pkg::*;
(
   input logic        clock,
   input logic        reset,
   hbrl_req_if.sink   req_chan,
   hbrl_rsp_if.source rsp_chan
);

   seq_ctrl_type    seq_ctrl;
   dp_status_type   dp_status;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic            rsp_valid;

   // Gather the request fields
   assign req_payload = '{opcode:        req_chan.opcode,
                          query_value:   req_chan.query_value,
                          load_lower:    req_chan.load_lower,
                          load_upper:    req_chan.load_upper,
                          load_height:   req_chan.load_height,
                          load_distinct: req_chan.load_distinct};

   assign req_chan.ready = seq_ctrl.word.accept;

   hbrl_sequencer u_sequencer (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (opcode_type'(req_chan.opcode)),
      .dp_status  (dp_status),
      .seq_ctrl   (seq_ctrl)
   );

   hbrl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .seq_ctrl    (seq_ctrl),
      .req_payload (req_payload),
      .rsp_ready   (rsp_chan.ready),
      .dp_status   (dp_status),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   // Drive the response channel
   assign rsp_chan.valid          = rsp_valid;
   assign rsp_chan.status         = rsp_payload.status;
   assign rsp_chan.found_index    = rsp_payload.found_index;
   assign rsp_chan.found_lower    = rsp_payload.found_lower;
   assign rsp_chan.found_upper    = rsp_payload.found_upper;
   assign rsp_chan.found_height   = rsp_payload.found_height;
   assign rsp_chan.found_distinct = rsp_payload.found_distinct;
   assign rsp_chan.sum_heights    = rsp_payload.sum_heights;
   assign rsp_chan.sum_distincts  = rsp_payload.sum_distincts;
   assign rsp_chan.bins_loaded    = rsp_payload.bins_loaded;

endmodule
